// ===== rtl/battery_soc_sag_compensator_defines.svh =====
// Assertion macros used by the checker file of the block.
`ifndef BATTERY_SOC_SAG_COMPENSATOR_DEFINES_SVH
`define BATTERY_SOC_SAG_COMPENSATOR_DEFINES_SVH

// Same-cycle implication, sampled on clock, disabled during reset.
`define BSC_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("bsc check failed");

// Next-cycle implication, sampled on clock, disabled during reset.
`define BSC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("bsc check failed");

`endif

// ===== rtl/bsc_pkg.sv =====
package bsc_pkg;

   localparam int unsigned PcWidth = 4;
   typedef logic [PcWidth-1:0] pc_type;

   localparam logic [15:0] RawMax   = 16'd25600;
   localparam logic [6:0]  PctFull  = 7'd100;
   localparam logic [6:0]  PctMul   = 7'd100;
   localparam logic [6:0]  SatMul   = 7'd101;
   localparam logic [9:0]  VcellMul = 10'd625;
   localparam logic [2:0]  DivLast  = 3'd6;

   localparam logic [14:0] RstDefaultFull = 15'd22528;
   localparam logic [6:0]  RstLearnMin    = 7'd80;
   localparam logic [22:0] RstSagDetect   = 23'd3700000;
   localparam logic [22:0] RstSagRelease  = 23'd3800000;
   localparam logic [15:0] RstHeavyRate   = 16'd1500;
   localparam logic [6:0]  RstSagMinDrop  = 7'd6;
   localparam logic [6:0]  RstMaxDrop     = 7'd3;
   localparam logic [6:0]  RstMaxRise     = 7'd5;

   localparam pc_type PcLearn  = 4'd0;
   localparam pc_type PcSelDiv = 4'd1;
   localparam pc_type PcLimit  = 4'd2;
   localparam pc_type PcSat    = 4'd3;
   localparam pc_type PcDiv    = 4'd4;
   localparam pc_type PcQDone  = 4'd5;
   localparam pc_type PcUv     = 4'd6;
   localparam pc_type PcFirst  = 4'd7;
   localparam pc_type PcEnter  = 4'd8;
   localparam pc_type PcHold   = 4'd9;
   localparam pc_type PcSlew   = 4'd10;
   localparam pc_type PcOut    = 4'd11;

   typedef struct packed {
      logic [15:0]        soc_raw;
      logic [15:0]        vcell_raw;
      logic signed [15:0] crate_rate;
      logic               crate_valid;
      logic               charger_full;
   } req_type;

   typedef struct packed {
      logic [6:0] soc_percent;
      logic       sag_hold;
   } rsp_type;

   typedef struct packed {
      logic [14:0] default_full_x256;
      logic [6:0]  learn_min_percent;
      logic [22:0] sag_detect_uv;
      logic [22:0] sag_release_uv;
      logic [15:0] heavy_load_rate;
      logic [6:0]  sag_min_drop;
      logic [6:0]  max_drop_step;
      logic [6:0]  max_rise_step;
   } cfg_type;

   typedef enum logic [2:0] {
      CSR_DEFAULT_FULL,
      CSR_LEARN_MIN,
      CSR_SAG_DETECT,
      CSR_SAG_RELEASE,
      CSR_HEAVY_RATE,
      CSR_SAG_MIN_DROP,
      CSR_MAX_DROP,
      CSR_MAX_RISE
   } csr_index_type;

   typedef enum logic [3:0] {
      OP_IDLE,
      OP_LEARN,
      OP_SELDIV,
      OP_LIMIT,
      OP_SAT,
      OP_DIV,
      OP_QDONE,
      OP_UV,
      OP_FIRST,
      OP_ENTER,
      OP_HOLD,
      OP_SLEW,
      OP_OUT
   } micro_op_type;

   typedef enum logic [2:0] {
      J_NEXT,
      J_DIVZ,
      J_SAT,
      J_LOOP,
      J_FIRST,
      J_END
   } jump_type;

   typedef struct packed {
      micro_op_type op;
      jump_type     jump;
      pc_type       target;
      logic         cnt_load;
   } cw_type;

   typedef struct packed {
      logic         load;
      micro_op_type op;
   } ctrl_type;

   typedef struct packed {
      logic       divz;
      logic       sat;
      logic       first;
      logic [6:0] corr;
      logic       sag;
   } status_type;

   function automatic cw_type microcode(input pc_type pc);
      cw_type cw;
      unique case (pc)
         PcLearn:  cw = '{op: OP_LEARN,  jump: J_NEXT,  target: PcSelDiv, cnt_load: 1'b0};
         PcSelDiv: cw = '{op: OP_SELDIV, jump: J_NEXT,  target: PcLimit,  cnt_load: 1'b0};
         PcLimit:  cw = '{op: OP_LIMIT,  jump: J_DIVZ,  target: PcUv,     cnt_load: 1'b0};
         PcSat:    cw = '{op: OP_SAT,    jump: J_SAT,   target: PcUv,     cnt_load: 1'b1};
         PcDiv:    cw = '{op: OP_DIV,    jump: J_LOOP,  target: PcDiv,    cnt_load: 1'b0};
         PcQDone:  cw = '{op: OP_QDONE,  jump: J_NEXT,  target: PcUv,     cnt_load: 1'b0};
         PcUv:     cw = '{op: OP_UV,     jump: J_NEXT,  target: PcFirst,  cnt_load: 1'b0};
         PcFirst:  cw = '{op: OP_FIRST,  jump: J_FIRST, target: PcOut,    cnt_load: 1'b0};
         PcEnter:  cw = '{op: OP_ENTER,  jump: J_NEXT,  target: PcHold,   cnt_load: 1'b0};
         PcHold:   cw = '{op: OP_HOLD,   jump: J_NEXT,  target: PcSlew,   cnt_load: 1'b0};
         PcSlew:   cw = '{op: OP_SLEW,   jump: J_NEXT,  target: PcOut,    cnt_load: 1'b0};
         PcOut:    cw = '{op: OP_OUT,    jump: J_END,   target: PcOut,    cnt_load: 1'b0};
         default:  cw = '{op: OP_IDLE,   jump: J_END,   target: PcLearn,  cnt_load: 1'b0};
      endcase
      return cw;
   endfunction

endpackage

// ===== rtl/bsc_datapath.sv =====
module bsc_datapath (
   input  logic                clock,
   input  logic                reset,
   input  bsc_pkg::ctrl_type   ctrl,
   input  bsc_pkg::req_type    req,
   input  bsc_pkg::cfg_type    cfg,
   output bsc_pkg::status_type status
);

   logic [14:0] raw_ff, raw_in;
   logic [15:0] vraw_ff, vraw_in;
   logic [15:0] rate_ff, rate_in;
   logic        rvalid_ff, rvalid_in;
   logic        full_ff, full_in;
   logic [14:0] learned_ff, learned_in;
   logic [14:0] div_ff, div_in;
   logic [21:0] num_ff, num_in;
   logic [21:0] lim_ff, lim_in;
   logic [21:0] dsr_ff, dsr_in;
   logic [6:0]  quo_ff, quo_in;
   logic [6:0]  corr_ff, corr_in;
   logic [22:0] uv_ff, uv_in;
   logic        heavy_ff, heavy_in;
   logic [6:0]  shown_ff, shown_in;
   logic        shown_valid_ff, shown_valid_in;
   logic        sag_ff, sag_in;

   logic [14:0] learn_floor;
   logic [25:0] uv_prod;
   logic [16:0] rate_mag;
   logic [6:0]  drop;
   logic [6:0]  rise;

   assign learn_floor = {cfg.learn_min_percent, 8'd0};
   assign uv_prod     = {10'd0, vraw_ff} * {16'd0, bsc_pkg::VcellMul};
   assign rate_mag    = !rvalid_ff ? 17'd0 :
                        rate_ff[15] ? (17'h10000 - {1'b0, rate_ff}) : {1'b0, rate_ff};
   assign drop        = shown_ff - corr_ff;
   assign rise        = corr_ff - shown_ff;

   always_comb begin
      raw_in         = raw_ff;
      vraw_in        = vraw_ff;
      rate_in        = rate_ff;
      rvalid_in      = rvalid_ff;
      full_in        = full_ff;
      learned_in     = learned_ff;
      div_in         = div_ff;
      num_in         = num_ff;
      lim_in         = lim_ff;
      dsr_in         = dsr_ff;
      quo_in         = quo_ff;
      corr_in        = corr_ff;
      uv_in          = uv_ff;
      heavy_in       = heavy_ff;
      shown_in       = shown_ff;
      shown_valid_in = shown_valid_ff;
      sag_in         = sag_ff;
      if (ctrl.load) begin
         raw_in    = (req.soc_raw > bsc_pkg::RawMax) ? bsc_pkg::RawMax[14:0]
                                                     : req.soc_raw[14:0];
         vraw_in   = req.vcell_raw;
         rate_in   = req.crate_rate;
         rvalid_in = req.crate_valid;
         full_in   = req.charger_full;
      end
      unique case (ctrl.op)
         bsc_pkg::OP_IDLE: begin
         end
         bsc_pkg::OP_LEARN: begin
            if (full_ff && (raw_ff[14:8] >= cfg.learn_min_percent)) begin
               learned_in = raw_ff;
            end
         end
         bsc_pkg::OP_SELDIV: begin
            if ((learned_ff != 15'd0) && (learned_ff >= learn_floor)) begin
               div_in = learned_ff;
            end else begin
               div_in = cfg.default_full_x256;
            end
            num_in = {7'd0, raw_ff} * {15'd0, bsc_pkg::PctMul};
         end
         bsc_pkg::OP_LIMIT: begin
            lim_in  = {7'd0, div_ff} * {15'd0, bsc_pkg::SatMul};
            corr_in = bsc_pkg::PctFull;
         end
         bsc_pkg::OP_SAT: begin
            corr_in = bsc_pkg::PctFull;
            dsr_in  = {1'b0, div_ff, 6'd0};
            quo_in  = 7'd0;
         end
         bsc_pkg::OP_DIV: begin
            if (num_ff >= dsr_ff) begin
               num_in = num_ff - dsr_ff;
               quo_in = {quo_ff[5:0], 1'b1};
            end else begin
               quo_in = {quo_ff[5:0], 1'b0};
            end
            dsr_in = dsr_ff >> 1;
         end
         bsc_pkg::OP_QDONE: begin
            corr_in = quo_ff;
         end
         bsc_pkg::OP_UV: begin
            uv_in    = uv_prod[25:3];
            heavy_in = rate_mag >= {1'b0, cfg.heavy_load_rate};
         end
         bsc_pkg::OP_FIRST: begin
            if (!shown_valid_ff) begin
               shown_valid_in = 1'b1;
               sag_in         = 1'b0;
            end
         end
         bsc_pkg::OP_ENTER: begin
            if (!sag_ff && (uv_ff < cfg.sag_detect_uv) && heavy_ff &&
                (corr_ff <= shown_ff) && (drop >= cfg.sag_min_drop)) begin
               sag_in = 1'b1;
            end
         end
         bsc_pkg::OP_HOLD: begin
            if (sag_ff) begin
               priority if ((uv_ff >= cfg.sag_release_uv) || !heavy_ff) begin
                  sag_in = 1'b0;
               end else if (corr_ff < shown_ff) begin
                  corr_in = shown_ff - 7'd1;
               end else if (corr_ff > shown_ff) begin
                  corr_in = shown_ff;
               end else begin
                  corr_in = corr_ff;
               end
            end
         end
         bsc_pkg::OP_SLEW: begin
            if (!sag_ff) begin
               priority if ((corr_ff < shown_ff) && (drop > cfg.max_drop_step)) begin
                  corr_in = shown_ff - cfg.max_drop_step;
               end else if ((corr_ff > shown_ff) && (rise > cfg.max_rise_step)) begin
                  corr_in = shown_ff + cfg.max_rise_step;
               end else begin
                  corr_in = corr_ff;
               end
            end
         end
         bsc_pkg::OP_OUT: begin
            shown_in = corr_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      raw_ff    <= raw_in;
      vraw_ff   <= vraw_in;
      rate_ff   <= rate_in;
      rvalid_ff <= rvalid_in;
      full_ff   <= full_in;
      div_ff    <= div_in;
      num_ff    <= num_in;
      lim_ff    <= lim_in;
      dsr_ff    <= dsr_in;
      quo_ff    <= quo_in;
      corr_ff   <= corr_in;
      uv_ff     <= uv_in;
      heavy_ff  <= heavy_in;
      if (reset) begin
         learned_ff     <= 15'd0;
         shown_ff       <= 7'd0;
         shown_valid_ff <= 1'b0;
         sag_ff         <= 1'b0;
      end else begin
         learned_ff     <= learned_in;
         shown_ff       <= shown_in;
         shown_valid_ff <= shown_valid_in;
         sag_ff         <= sag_in;
      end
   end

   assign status.divz  = (div_ff == 15'd0);
   assign status.sat   = (num_ff >= lim_ff);
   assign status.first = !shown_valid_ff;
   assign status.corr  = corr_ff;
   assign status.sag   = sag_ff;

endmodule

// ===== rtl/battery_soc_sag_compensator.sv =====
// Channel  Handshake              Payload              Direction
// req      req_valid / req_stall  bsc_pkg::req_type    in, one gauge poll per beat
// rsp      rsp_valid / rsp_stall  bsc_pkg::rsp_type    out, one displayed percent per beat
// csr      csr_valid / csr_ready  csr_index, csr_data  in, register write per beat
//
// A microcoded sequencer runs one poll at a time through a 12-step program with a
// seven-step restoring divide loop; the divide is skipped when the divisor is zero
// or the quotient saturates, and the sag and slew steps are skipped for the first
// sample. The next beat is taken the cycle after the result is loaded. A stalled
// result holds the program at its last step. Synchronous reset clears the learned
// point, the shown value and the sag hold, and restores the configuration
// registers to their reset values.
module battery_soc_sag_compensator (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  bsc_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output bsc_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [2:0]       csr_index,
   input  logic [22:0]      csr_data
);

   bsc_pkg::cfg_type    cfg_ff, cfg_in;
   logic                running_ff, running_in;
   bsc_pkg::pc_type     pc_ff, pc_in;
   logic [2:0]          cnt_ff, cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   bsc_pkg::rsp_type    rsp_data_ff, rsp_data_in;

   bsc_pkg::cw_type     cw;
   bsc_pkg::ctrl_type   ctrl;
   bsc_pkg::status_type status;
   logic                accept;
   logic                blocked;
   logic                finish;
   bsc_pkg::pc_type     pc_next;

   assign req_stall = reset | running_ff;
   assign csr_ready = !reset;
   assign accept    = req_valid && !req_stall;
   assign blocked   = rsp_valid_ff && rsp_stall;
   assign cw        = bsc_pkg::microcode(pc_ff);
   assign pc_next   = pc_ff + bsc_pkg::pc_type'(1);
   assign finish    = running_ff && (cw.jump == bsc_pkg::J_END) && !blocked;

   assign ctrl.load = accept;
   assign ctrl.op   = running_ff ? cw.op : bsc_pkg::OP_IDLE;

   bsc_datapath u_datapath (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .req    (req_data),
      .cfg    (cfg_ff),
      .status (status)
   );

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (bsc_pkg::csr_index_type'(csr_index))
            bsc_pkg::CSR_DEFAULT_FULL: cfg_in.default_full_x256 = csr_data[14:0];
            bsc_pkg::CSR_LEARN_MIN:    cfg_in.learn_min_percent = csr_data[6:0];
            bsc_pkg::CSR_SAG_DETECT:   cfg_in.sag_detect_uv     = csr_data;
            bsc_pkg::CSR_SAG_RELEASE:  cfg_in.sag_release_uv    = csr_data;
            bsc_pkg::CSR_HEAVY_RATE:   cfg_in.heavy_load_rate   = csr_data[15:0];
            bsc_pkg::CSR_SAG_MIN_DROP: cfg_in.sag_min_drop      = csr_data[6:0];
            bsc_pkg::CSR_MAX_DROP:     cfg_in.max_drop_step     = csr_data[6:0];
            bsc_pkg::CSR_MAX_RISE:     cfg_in.max_rise_step     = csr_data[6:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      running_in = running_ff;
      pc_in      = pc_ff;
      cnt_in     = cnt_ff;
      if (!running_ff) begin
         if (accept) begin
            running_in = 1'b1;
            pc_in      = bsc_pkg::PcLearn;
         end
      end else begin
         if (cw.cnt_load) begin
            cnt_in = bsc_pkg::DivLast;
         end else if (cw.jump == bsc_pkg::J_LOOP) begin
            cnt_in = cnt_ff - 3'd1;
         end
         unique case (cw.jump)
            bsc_pkg::J_NEXT:  pc_in = pc_next;
            bsc_pkg::J_DIVZ:  pc_in = status.divz ? cw.target : pc_next;
            bsc_pkg::J_SAT:   pc_in = status.sat ? cw.target : pc_next;
            bsc_pkg::J_LOOP:  pc_in = (cnt_ff != 3'd0) ? cw.target : pc_next;
            bsc_pkg::J_FIRST: pc_in = status.first ? cw.target : pc_next;
            bsc_pkg::J_END: begin
               if (blocked) begin
                  pc_in = cw.target;
               end else begin
                  running_in = 1'b0;
                  pc_in      = bsc_pkg::PcLearn;
               end
            end
            default: pc_in = bsc_pkg::PcLearn;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (finish) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.soc_percent = status.corr;
         rsp_data_in.sag_hold    = status.sag;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      cnt_ff      <= cnt_in;
      if (reset) begin
         cfg_ff.default_full_x256 <= bsc_pkg::RstDefaultFull;
         cfg_ff.learn_min_percent <= bsc_pkg::RstLearnMin;
         cfg_ff.sag_detect_uv     <= bsc_pkg::RstSagDetect;
         cfg_ff.sag_release_uv    <= bsc_pkg::RstSagRelease;
         cfg_ff.heavy_load_rate   <= bsc_pkg::RstHeavyRate;
         cfg_ff.sag_min_drop      <= bsc_pkg::RstSagMinDrop;
         cfg_ff.max_drop_step     <= bsc_pkg::RstMaxDrop;
         cfg_ff.max_rise_step     <= bsc_pkg::RstMaxRise;
         running_ff               <= 1'b0;
         pc_ff                    <= bsc_pkg::PcLearn;
         rsp_valid_ff             <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         running_ff   <= running_in;
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/bsc_checker.sv =====
`include "battery_soc_sag_compensator_defines.svh"

module bsc_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input bsc_pkg::rsp_type rsp_data
);

   `BSC_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))
   `BSC_ASSERT_NEXT(a_busy_after_beat, req_valid && !req_stall, req_stall)
   `BSC_ASSERT_NEXT(a_no_early_rsp, req_valid && !req_stall, !$rose(rsp_valid))
   `BSC_ASSERT_IMPL(a_pct_range, rsp_valid, rsp_data.soc_percent <= 7'd100)

endmodule

bind battery_soc_sag_compensator bsc_checker u_bsc_checker (.*);

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
   import bsc_pkg::*;

   localparam int SettleCycles = 20;
   localparam int MaxGap       = 24;
   localparam int ChunkPolls   = 62;
   localparam int Chunks       = 8;
   localparam int VcellLow     = 40000;
   localparam int VcellHigh    = 52000;

   logic       clock     = 1'b0;
   logic       reset     = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   req_type    req_data  = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   rsp_type    rsp_data;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [2:0] csr_index = '0;
   logic [22:0] csr_data = '0;

   battery_soc_sag_compensator dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #5 clock = ~clock;

   cfg_type     model_cfg;
   logic [14:0] learned_full = '0;
   int          shown_pct    = 0;
   bit          shown_valid  = 1'b0;
   bit          sag_on       = 1'b0;
   int          walk_raw     = 12800;

   rsp_type expected_display[$];
   rsp_type want;
   int      failures  = 0;
   int      gap_pct   = 0;
   int      stall_pct = 0;

   function automatic cfg_type default_settings();
      cfg_type s;
      s.default_full_x256 = RstDefaultFull;
      s.learn_min_percent = RstLearnMin;
      s.sag_detect_uv     = RstSagDetect;
      s.sag_release_uv    = RstSagRelease;
      s.heavy_load_rate   = RstHeavyRate;
      s.sag_min_drop      = RstSagMinDrop;
      s.max_drop_step     = RstMaxDrop;
      s.max_rise_step     = RstMaxRise;
      return s;
   endfunction

   function automatic rsp_type predict_display(input req_type poll);
      int unsigned raw, raw_pct, divisor, cell_uv, rate_mag, quotient;
      int          corrected, prev;
      logic [15:0] rbits;
      bit          heavy;
      rsp_type     r;
      raw = poll.soc_raw;
      if (raw > 25600) raw = 25600;
      raw_pct = raw / 256;
      if (poll.charger_full && raw_pct >= model_cfg.learn_min_percent) learned_full = raw[14:0];
      if (learned_full != 0 && learned_full >= model_cfg.learn_min_percent * 256)
         divisor = learned_full;
      else
         divisor = model_cfg.default_full_x256;
      if (divisor == 0) begin
         corrected = 100;
      end else begin
         quotient = (raw * 100) / divisor;
         corrected = (quotient > 100) ? 100 : int'(quotient);
      end
      cell_uv = (poll.vcell_raw * 625) / 8;
      rbits = poll.crate_rate;
      if (!poll.crate_valid) rate_mag = 0;
      else if (rbits[15]) rate_mag = 65536 - rbits;
      else rate_mag = rbits;
      heavy = rate_mag >= model_cfg.heavy_load_rate;
      r.sag_hold = 1'b0;
      if (!shown_valid) begin
         shown_pct = corrected;
         shown_valid = 1'b1;
         sag_on = 1'b0;
         r.soc_percent = corrected[6:0];
         return r;
      end
      prev = shown_pct;
      if (!sag_on && cell_uv < model_cfg.sag_detect_uv && heavy &&
          prev - corrected >= int'(model_cfg.sag_min_drop))
         sag_on = 1'b1;
      if (sag_on) begin
         if (cell_uv >= model_cfg.sag_release_uv || !heavy) begin
            sag_on = 1'b0;
         end else if (corrected < prev) begin
            corrected = (prev > 0) ? prev - 1 : 0;
         end else if (corrected > prev) begin
            corrected = prev;
         end
      end
      if (!sag_on) begin
         if (corrected < prev && prev - corrected > int'(model_cfg.max_drop_step))
            corrected = prev - int'(model_cfg.max_drop_step);
         else if (corrected > prev && corrected - prev > int'(model_cfg.max_rise_step))
            corrected = prev + int'(model_cfg.max_rise_step);
      end
      shown_pct = corrected & 127;
      r.soc_percent = shown_pct[6:0];
      r.sag_hold = sag_on;
      return r;
   endfunction

   function automatic req_type poll_of(input int raw, input int vcell, input int rate,
                                       input bit rvalid, input bit full);
      req_type p;
      p.soc_raw      = 16'(raw);
      p.vcell_raw    = 16'(vcell);
      p.crate_rate   = 16'(rate);
      p.crate_valid  = rvalid;
      p.charger_full = full;
      return p;
   endfunction

   function automatic req_type random_poll();
      int          raw, vcell, mag, center;
      int unsigned sel;
      logic [15:0] rbits;
      sel = $urandom_range(99);
      if (sel < 60) begin
         walk_raw = walk_raw + int'($urandom_range(3000)) - 1500;
         if (walk_raw < 0) walk_raw = 0;
         if (walk_raw > 25600) walk_raw = 25600;
         raw = walk_raw;
      end else if (sel < 90) begin
         raw = $urandom_range(25600);
         walk_raw = raw;
      end else begin
         raw = $urandom_range(65535);
      end
      sel = $urandom_range(99);
      if (sel < 60) begin
         center = ($urandom_range(1) ? model_cfg.sag_detect_uv : model_cfg.sag_release_uv)
                  * 8 / 625;
         vcell = center + int'($urandom_range(4000)) - 2000;
         if (vcell < 0) vcell = 0;
         if (vcell > 65535) vcell = 65535;
      end else begin
         vcell = $urandom_range(65535);
      end
      sel = $urandom_range(99);
      if (sel < 55) begin
         mag = int'(model_cfg.heavy_load_rate) + int'($urandom_range(1000)) - 500;
         if (mag < 0) mag = 0;
         if (mag > 32768) mag = 32768;
         rbits = $urandom_range(1) ? 16'(-mag) : 16'(mag);
      end else if (sel < 90) begin
         rbits = 16'($urandom_range(65535));
      end else begin
         case ($urandom_range(2))
            0: rbits = 16'h8000;
            1: rbits = 16'h7fff;
            default: rbits = 16'h0000;
         endcase
      end
      return poll_of(raw, vcell, int'(rbits), $urandom_range(99) < 90,
                     $urandom_range(99) < 15);
   endfunction

   function automatic cfg_type random_settings();
      cfg_type s;
      s.default_full_x256 = 15'($urandom_range(20480, 25600));
      s.learn_min_percent = 7'($urandom_range(100));
      s.sag_detect_uv     = 23'($urandom_range(3500000, 4000000));
      if ($urandom_range(3) == 0)
         s.sag_release_uv = 23'($urandom_range(5119921));
      else
         s.sag_release_uv = s.sag_detect_uv + 23'($urandom_range(200000));
      s.heavy_load_rate   = 16'($urandom_range(4000));
      s.sag_min_drop      = 7'($urandom_range(15));
      s.max_drop_step     = 7'($urandom_range(10));
      s.max_rise_step     = 7'($urandom_range(10));
      return s;
   endfunction

   task automatic settle();
      req_valid <= 1'b0;
      while (expected_display.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic apply_settings(input cfg_type s);
      csr_index_type idx;
      logic [22:0]   value;
      settle();
      for (int i = 0; i < 8; i++) begin
         idx = csr_index_type'(i);
         case (idx)
            CSR_DEFAULT_FULL: value = 23'(s.default_full_x256);
            CSR_LEARN_MIN:    value = 23'(s.learn_min_percent);
            CSR_SAG_DETECT:   value = s.sag_detect_uv;
            CSR_SAG_RELEASE:  value = s.sag_release_uv;
            CSR_HEAVY_RATE:   value = 23'(s.heavy_load_rate);
            CSR_SAG_MIN_DROP: value = 23'(s.sag_min_drop);
            CSR_MAX_DROP:     value = 23'(s.max_drop_step);
            default:          value = 23'(s.max_rise_step);
         endcase
         csr_valid <= 1'b1;
         csr_index <= idx;
         csr_data  <= value;
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
      model_cfg = s;
   endtask

   task automatic send_poll(input req_type poll);
      if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, MaxGap)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= poll;
      do @(posedge clock); while (req_stall);
      expected_display.push_back(predict_display(poll));
   endtask

   task automatic report_mismatch(input string field, input int expected, input int actual);
      failures++;
      if (failures <= 10)
         $display("mismatch on %s: expected %0d, got %0d", field, expected, actual);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_display.size() == 0) begin
            report_mismatch("unexpected beat soc_percent", -1, rsp_data.soc_percent);
         end else begin
            want = expected_display.pop_front();
            if (rsp_data.soc_percent !== want.soc_percent)
               report_mismatch("soc_percent", want.soc_percent, rsp_data.soc_percent);
            if (rsp_data.sag_hold !== want.sag_hold)
               report_mismatch("sag_hold", want.sag_hold, rsp_data.sag_hold);
         end
      end
      rsp_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
   end

   task automatic test_first_sample();
      send_poll(poll_of(65535, 0, -32768, 1'b1, 1'b0));
   endtask

   task automatic test_field_extremes();
      send_poll(poll_of(0, 65535, 32767, 1'b0, 1'b0));
      send_poll(poll_of(25601, 0, 0, 1'b1, 1'b0));
      send_poll(poll_of(25600, 65535, -1, 1'b1, 1'b0));
      send_poll(poll_of(0, 0, -32768, 1'b1, 1'b0));
   endtask

   task automatic test_learning();
      cfg_type s;
      send_poll(poll_of(20479, VcellHigh, 0, 1'b1, 1'b1));
      send_poll(poll_of(20480, VcellHigh, 0, 1'b1, 1'b1));
      send_poll(poll_of(12800, VcellHigh, 0, 1'b1, 1'b0));
      s = model_cfg;
      s.learn_min_percent = 7'd90;
      apply_settings(s);
      send_poll(poll_of(12800, VcellHigh, 0, 1'b1, 1'b0));
      s.learn_min_percent = 7'd127;
      apply_settings(s);
      send_poll(poll_of(25600, VcellHigh, 0, 1'b1, 1'b1));
      apply_settings(default_settings());
      send_poll(poll_of(12800, VcellHigh, 0, 1'b1, 1'b0));
   endtask

   task automatic test_sag_hold();
      repeat (6) send_poll(poll_of(20480, VcellHigh, 0, 1'b1, 1'b0));
      send_poll(poll_of(10240, VcellLow, -3000, 1'b1, 1'b0));
      send_poll(poll_of(10240, VcellLow, -3000, 1'b1, 1'b0));
      send_poll(poll_of(25600, VcellLow, 3000, 1'b1, 1'b0));
      send_poll(poll_of(10240, VcellLow, 100, 1'b1, 1'b0));
      send_poll(poll_of(10240, VcellLow, -32768, 1'b1, 1'b0));
      send_poll(poll_of(10240, VcellHigh, -3000, 1'b1, 1'b0));
      send_poll(poll_of(0, VcellLow, -32768, 1'b0, 1'b0));
   endtask

   task automatic test_zero_divisor();
      cfg_type s;
      s = model_cfg;
      s.learn_min_percent = 7'd127;
      s.default_full_x256 = 15'd0;
      apply_settings(s);
      send_poll(poll_of(0, VcellHigh, 0, 1'b1, 1'b0));
      send_poll(poll_of(65535, VcellHigh, 0, 1'b1, 1'b1));
      apply_settings(default_settings());
   endtask

   task automatic test_random_traffic();
      cfg_type s;
      for (int chunk = 0; chunk < Chunks; chunk++) begin
         case (chunk % 4)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 46; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 46; end
            default: begin gap_pct = 9; stall_pct = 9; end
         endcase
         case (chunk)
            0: s = default_settings();
            2: s = '{default_full_x256: 15'd20480, learn_min_percent: 7'd0,
                     sag_detect_uv: 23'd0, sag_release_uv: 23'd0, heavy_load_rate: 16'd0,
                     sag_min_drop: 7'd0, max_drop_step: 7'd0, max_rise_step: 7'd0};
            4: s = '{default_full_x256: 15'd25600, learn_min_percent: 7'd100,
                     sag_detect_uv: 23'd5119921, sag_release_uv: 23'd5119921,
                     heavy_load_rate: 16'd32768, sag_min_drop: 7'd100,
                     max_drop_step: 7'd100, max_rise_step: 7'd100};
            6: begin
               s = default_settings();
               s.learn_min_percent = 7'd101;
            end
            default: s = random_settings();
         endcase
         apply_settings(s);
         repeat (ChunkPolls) send_poll(random_poll());
      end
   endtask

   initial begin
      model_cfg = default_settings();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_first_sample();
      test_field_extremes();
      test_learning();
      test_sag_hold();
      test_zero_divisor();
      test_random_traffic();
      settle();
      if (failures == 0 && expected_display.size() == 0) begin
         $display("battery_soc_sag_compensator regression: pass");
      end else begin
         $display("battery_soc_sag_compensator regression: fail");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("battery_soc_sag_compensator regression: fail");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/bsc_pkg.sv
rtl/bsc_datapath.sv
rtl/battery_soc_sag_compensator.sv
rtl/bsc_checker.sv
tb/sv/tb.sv
